FILE: rtl/core/sd_spi_command_response_engine_macros.svh
// ----------------------------------------------------------------------------
// SD SPI command/response engine assertion macros
// Shared shorthands for the concurrent checks in the engine's RTL.
// ----------------------------------------------------------------------------
`ifndef SD_SPI_COMMAND_RESPONSE_ENGINE_MACROS_SVH
`define SD_SPI_COMMAND_RESPONSE_ENGINE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SDSPI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication that must hold at every clock edge outside reset.
`define SDSPI_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/core/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// SD SPI engine package
// Types, constants and helpers shared by the command/response engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int unsigned MAX_BLOCK_BYTES = 512;
  localparam int unsigned LEN_W           = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int unsigned POLL_W          = 8;
  localparam int unsigned CMD_BYTES       = 6;
  localparam int unsigned STEP_W          = $clog2(CMD_BYTES);
  localparam int unsigned JOB_FIFO_DEPTH  = 2;
  localparam int unsigned JOB_PTR_W       = $clog2(JOB_FIFO_DEPTH);
  localparam int unsigned JOB_CNT_W       = $clog2(JOB_FIFO_DEPTH + 1);

  localparam logic [7:0] CMD_START   = 8'h40;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;
  localparam logic [7:0] START_TOKEN = 8'hFE;
  localparam logic [7:0] R1_READY    = 8'h00;
  localparam logic [7:0] R1_IDLE     = 8'h01;
  localparam logic [7:0] CRC_CMD0    = 8'h95;
  localparam logic [7:0] CRC_CMD8    = 8'h87;
  localparam logic [7:0] CRC_OTHER   = 8'h01;
  localparam logic [7:0] IDX_CMD0    = 8'd0;
  localparam logic [7:0] IDX_CMD8    = 8'd8;
  localparam logic [7:0] IDX_LIMIT   = 8'd64;
  localparam logic [POLL_W-1:0] TAIL_BYTES = POLL_W'(3);

  typedef enum logic [1:0] {
    FUNC_CMD   = 2'd0,
    FUNC_RESP  = 2'd1,
    FUNC_BLOCK = 2'd2,
    FUNC_BYTE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ILLEGAL   = 3'd1,
    ST_TIMEOUT   = 3'd2,
    ST_BAD_R1    = 3'd3,
    ST_BAD_TOKEN = 3'd4,
    ST_BLOCK_R1  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_RPOLL  = 3'd1,
    PH_RDATA  = 3'd2,
    PH_RTRAIL = 3'd3,
    PH_BR1    = 3'd4,
    PH_BTOK   = 3'd5,
    PH_BDATA  = 3'd6,
    PH_BTAIL  = 3'd7
  } phase_e;

  // Work handed from the classifier to the result sequencer.
  typedef enum logic [1:0] {
    JOB_FILL    = 2'd0,  // one fill byte to transmit
    JOB_STATUS  = 2'd1,  // one final status
    JOB_DELIVER = 2'd2,  // received byte, then a fill byte
    JOB_CMD     = 2'd3   // six-byte command frame
  } job_op_e;

  typedef struct packed {
    job_op_e     op;
    logic [5:0]  idx;
    logic [31:0] arg;
    logic [7:0]  rx;
    status_e     status;
  } job_t;

  // Saturate a requested length to the largest block the engine handles.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [9:0] n);
    logic [LEN_W-1:0] r;
    if (32'(n) > 32'(MAX_BLOCK_BYTES)) begin
      r = LEN_W'(MAX_BLOCK_BYTES);
    end else begin
      r = LEN_W'(n);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/sd_spi_if.sv
// ----------------------------------------------------------------------------
// SD SPI engine channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface sd_spi_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  cmd_index;
  logic [31:0] cmd_argument;
  logic [9:0]  byte_count;
  logic [7:0]  miso_byte;

  modport source (output valid, output func, output cmd_index, output cmd_argument,
                  output byte_count, output miso_byte, input ready);
  modport sink   (input valid, input func, input cmd_index, input cmd_argument,
                  input byte_count, input miso_byte, output ready);
endinterface

interface sd_spi_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_value;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output kind, output byte_value, output status,
                  output last, input ready);
  modport sink   (input valid, input kind, input byte_value, input status,
                  input last, output ready);
endinterface

FILE: rtl/core/sd_spi_command_response_engine.sv
// ----------------------------------------------------------------------------
// SD card SPI-mode command/response engine
// Frames SD commands and parses card replies one exchanged byte at a time.
// ----------------------------------------------------------------------------
// Each request transaction is one step of an SD SPI exchange: issue a command,
// start a response read, start a block read, or report the byte the card
// returned in the exchange the engine last asked for. The engine answers with
// result transactions: bytes to transmit, received bytes handed over, and a
// final status, the last result of each request being marked by last. A
// command gives six bytes (start/index, argument MSB first, CRC); a response
// read polls with 0xFF for up to 256 bytes and accepts R1 0x00 or 0x01; a
// block read waits for R1 0x00 and the 0xFE token, hands over the data and
// then discards three bytes. Lengths above 512 bytes are saturated.
// Timing: the front end classifies a request in the cycle it is accepted and
// takes one request per cycle while its two-entry job queue has room. The
// result sequencer takes up a job and then gives one result per cycle while
// the output register is free to load; a command request gives six results,
// a data byte two and any other request one. The first result of a request
// passes from the job queue through the sequencer's job register into the
// output register. The sequencer's result rate sets the sustained rate.
// ----------------------------------------------------------------------------
module sd_spi_command_response_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  sd_spi_req_if.sink   req_i,
  sd_spi_rsp_if.source rsp_o
);

  // Jobs travel from the classifier through the queue to the sequencer.
  sdspi_pkg::job_t push_job;
  sdspi_pkg::job_t head_job;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  // Front end: owns the protocol phase, poll counter and byte counters, and
  // turns every accepted request into at most one job.
  sdspi_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  // The queue lets requests keep arriving while results are still draining.
  sdspi_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (full),
    .empty_o (empty)
  );

  // Back end: expands each job into its result transactions.
  sdspi_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (head_job),
    .empty_i (empty),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

endmodule

FILE: rtl/core/sdspi_front.sv
// ----------------------------------------------------------------------------
// SD SPI engine front end
// Accepts request items, tracks the protocol phase, queues at most one job each.
// ----------------------------------------------------------------------------
module sdspi_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  sd_spi_req_if.sink        req_i,
  input  logic              full_i,
  output logic              push_o,
  output sdspi_pkg::job_t   job_o
);

  sdspi_pkg::phase_e              phase_q, phase_d;
  logic [sdspi_pkg::POLL_W-1:0]   poll_q, poll_d;
  logic [sdspi_pkg::LEN_W-1:0]    done_q, done_d;
  logic [sdspi_pkg::LEN_W-1:0]    wanted_q, wanted_d;
  sdspi_pkg::status_e             pend_q, pend_d;

  logic                           accept;
  sdspi_pkg::func_e               func;
  logic [7:0]                     rx;
  logic                           rx_fill;
  logic [sdspi_pkg::POLL_W-1:0]   poll_inc;
  logic                           expired;
  logic [sdspi_pkg::LEN_W-1:0]    done_inc;
  logic [sdspi_pkg::LEN_W-1:0]    len;

  assign req_i.ready = !full_i;
  assign accept      = req_i.valid && !full_i;
  assign func        = sdspi_pkg::func_e'(req_i.func);
  assign rx          = req_i.miso_byte;
  assign rx_fill     = (rx == sdspi_pkg::FILL_BYTE);
  assign poll_inc    = poll_q + sdspi_pkg::POLL_W'(1);
  assign expired     = (poll_inc == '0);
  assign done_inc    = done_q + sdspi_pkg::LEN_W'(1);
  assign len         = sdspi_pkg::clamp_len(req_i.byte_count);

  // Next state.
  always_comb begin
    phase_d  = phase_q;
    poll_d   = poll_q;
    done_d   = done_q;
    wanted_d = wanted_q;
    pend_d   = pend_q;
    if (accept) begin
      unique case (func)
        sdspi_pkg::FUNC_CMD: begin
          phase_d = sdspi_pkg::PH_IDLE;
        end
        sdspi_pkg::FUNC_RESP, sdspi_pkg::FUNC_BLOCK: begin
          phase_d  = (func == sdspi_pkg::FUNC_RESP) ? sdspi_pkg::PH_RPOLL : sdspi_pkg::PH_BR1;
          poll_d   = '0;
          done_d   = '0;
          pend_d   = sdspi_pkg::ST_OK;
          wanted_d = len;
          if (func == sdspi_pkg::FUNC_RESP && len == '0) begin
            wanted_d = sdspi_pkg::LEN_W'(1);
          end
        end
        sdspi_pkg::FUNC_BYTE: begin
          unique case (phase_q)
            sdspi_pkg::PH_IDLE: begin
            end
            sdspi_pkg::PH_RPOLL: begin
              if (rx_fill) begin
                poll_d = poll_inc;
                if (expired) begin
                  pend_d  = sdspi_pkg::ST_TIMEOUT;
                  phase_d = sdspi_pkg::PH_RTRAIL;
                end
              end else if (rx != sdspi_pkg::R1_READY && rx != sdspi_pkg::R1_IDLE) begin
                pend_d  = sdspi_pkg::ST_BAD_R1;
                phase_d = sdspi_pkg::PH_RTRAIL;
              end else begin
                done_d  = sdspi_pkg::LEN_W'(1);
                pend_d  = sdspi_pkg::ST_OK;
                phase_d = (sdspi_pkg::LEN_W'(1) < wanted_q) ? sdspi_pkg::PH_RDATA
                                                            : sdspi_pkg::PH_RTRAIL;
              end
            end
            sdspi_pkg::PH_RDATA: begin
              done_d = done_inc;
              if (done_inc >= wanted_q) begin
                phase_d = sdspi_pkg::PH_RTRAIL;
              end
            end
            sdspi_pkg::PH_RTRAIL: begin
              phase_d = sdspi_pkg::PH_IDLE;
            end
            sdspi_pkg::PH_BR1, sdspi_pkg::PH_BTOK: begin
              if (rx_fill) begin
                poll_d = poll_inc;
                if (expired) begin
                  phase_d = sdspi_pkg::PH_IDLE;
                end
              end else if (phase_q == sdspi_pkg::PH_BR1 && rx == sdspi_pkg::R1_READY) begin
                phase_d = sdspi_pkg::PH_BTOK;
                poll_d  = '0;
              end else if (phase_q == sdspi_pkg::PH_BTOK && rx == sdspi_pkg::START_TOKEN) begin
                done_d  = '0;
                poll_d  = '0;
                phase_d = (wanted_q == '0) ? sdspi_pkg::PH_BTAIL : sdspi_pkg::PH_BDATA;
              end else begin
                phase_d = sdspi_pkg::PH_IDLE;
              end
            end
            sdspi_pkg::PH_BDATA: begin
              done_d = done_inc;
              if (done_inc >= wanted_q) begin
                phase_d = sdspi_pkg::PH_BTAIL;
                poll_d  = '0;
              end
            end
            sdspi_pkg::PH_BTAIL: begin
              poll_d = poll_inc;
              if (poll_inc >= sdspi_pkg::TAIL_BYTES) begin
                phase_d = sdspi_pkg::PH_IDLE;
              end
            end
          endcase
        end
      endcase
    end
  end

  // Job for the accepted item.
  always_comb begin
    push_o     = 1'b0;
    job_o.op   = sdspi_pkg::JOB_FILL;
    job_o.idx  = req_i.cmd_index[5:0];
    job_o.arg  = req_i.cmd_argument;
    job_o.rx   = rx;
    job_o.status = sdspi_pkg::ST_OK;
    if (accept) begin
      push_o = 1'b1;
      unique case (func)
        sdspi_pkg::FUNC_CMD: begin
          if (req_i.cmd_index >= sdspi_pkg::IDX_LIMIT) begin
            job_o.op     = sdspi_pkg::JOB_STATUS;
            job_o.status = sdspi_pkg::ST_ILLEGAL;
          end else begin
            job_o.op = sdspi_pkg::JOB_CMD;
          end
        end
        sdspi_pkg::FUNC_RESP, sdspi_pkg::FUNC_BLOCK: begin
          job_o.op = sdspi_pkg::JOB_FILL;
        end
        sdspi_pkg::FUNC_BYTE: begin
          unique case (phase_q)
            sdspi_pkg::PH_IDLE: begin
              push_o = 1'b0;
            end
            sdspi_pkg::PH_RPOLL: begin
              job_o.op = rx_fill ? sdspi_pkg::JOB_FILL : sdspi_pkg::JOB_DELIVER;
            end
            sdspi_pkg::PH_RDATA, sdspi_pkg::PH_BDATA: begin
              job_o.op = sdspi_pkg::JOB_DELIVER;
            end
            sdspi_pkg::PH_RTRAIL: begin
              job_o.op     = sdspi_pkg::JOB_STATUS;
              job_o.status = pend_q;
            end
            sdspi_pkg::PH_BR1, sdspi_pkg::PH_BTOK: begin
              if (rx_fill) begin
                if (expired) begin
                  job_o.op     = sdspi_pkg::JOB_STATUS;
                  job_o.status = sdspi_pkg::ST_TIMEOUT;
                end
              end else if (phase_q == sdspi_pkg::PH_BR1) begin
                if (rx != sdspi_pkg::R1_READY) begin
                  job_o.op     = sdspi_pkg::JOB_STATUS;
                  job_o.status = sdspi_pkg::ST_BLOCK_R1;
                end
              end else if (rx != sdspi_pkg::START_TOKEN) begin
                job_o.op     = sdspi_pkg::JOB_STATUS;
                job_o.status = sdspi_pkg::ST_BAD_TOKEN;
              end
            end
            sdspi_pkg::PH_BTAIL: begin
              if (poll_inc >= sdspi_pkg::TAIL_BYTES) begin
                job_o.op     = sdspi_pkg::JOB_STATUS;
                job_o.status = sdspi_pkg::ST_OK;
              end
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= sdspi_pkg::PH_IDLE;
      poll_q   <= '0;
      done_q   <= '0;
      wanted_q <= '0;
      pend_q   <= sdspi_pkg::ST_OK;
    end else begin
      phase_q  <= phase_d;
      poll_q   <= poll_d;
      done_q   <= done_d;
      wanted_q <= wanted_d;
      pend_q   <= pend_d;
    end
  end

endmodule

FILE: rtl/core/sdspi_job_fifo.sv
// ----------------------------------------------------------------------------
// SD SPI engine job queue
// Short first-in first-out buffer between the front end and the sequencer.
// ----------------------------------------------------------------------------
module sdspi_job_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sdspi_pkg::job_t job_i,
  input  logic            pop_i,
  output sdspi_pkg::job_t job_o,
  output logic            full_o,
  output logic            empty_o
);

  sdspi_pkg::job_t                   slot_q [sdspi_pkg::JOB_FIFO_DEPTH];
  logic [sdspi_pkg::JOB_PTR_W-1:0]   wr_q, rd_q;
  logic [sdspi_pkg::JOB_CNT_W-1:0]   cnt_q;
  logic                              do_push, do_pop;

  assign full_o  = (cnt_q == sdspi_pkg::JOB_CNT_W'(sdspi_pkg::JOB_FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + sdspi_pkg::JOB_PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + sdspi_pkg::JOB_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + sdspi_pkg::JOB_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - sdspi_pkg::JOB_CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/sdspi_back.sv
// ----------------------------------------------------------------------------
// SD SPI engine result sequencer
// Expands queued jobs into result transactions through an output register.
// ----------------------------------------------------------------------------
`include "sd_spi_command_response_engine_macros.svh"

module sdspi_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sdspi_pkg::job_t job_i,
  input  logic            empty_i,
  output logic            pop_o,
  sd_spi_rsp_if.source    rsp_o
);

  sdspi_pkg::job_t                 job_q, job_d;
  logic [sdspi_pkg::STEP_W-1:0]    step_q, step_d;
  logic                            busy_q, busy_d;
  logic                            vld_q, vld_d;
  sdspi_pkg::kind_e                kind_q, kind_d;
  logic [7:0]                      byte_q, byte_d;
  sdspi_pkg::status_e              stat_q, stat_d;
  logic                            last_q, last_d;

  logic                            can_load;
  sdspi_pkg::kind_e                r_kind;
  logic [7:0]                      r_byte;
  sdspi_pkg::status_e              r_stat;
  logic                            r_last;
  logic [7:0]                      crc;

  assign rsp_o.valid      = vld_q;
  assign rsp_o.kind       = kind_q;
  assign rsp_o.byte_value = byte_q;
  assign rsp_o.status     = stat_q;
  assign rsp_o.last       = last_q;

  assign can_load = !vld_q || rsp_o.ready;
  assign pop_o    = !busy_q && !empty_i;

  always_comb begin
    if ({2'b00, job_q.idx} == sdspi_pkg::IDX_CMD0) begin
      crc = sdspi_pkg::CRC_CMD0;
    end else if ({2'b00, job_q.idx} == sdspi_pkg::IDX_CMD8) begin
      crc = sdspi_pkg::CRC_CMD8;
    end else begin
      crc = sdspi_pkg::CRC_OTHER;
    end
  end

  // Result for the current step of the held job.
  always_comb begin
    r_kind = sdspi_pkg::KIND_TX;
    r_byte = sdspi_pkg::FILL_BYTE;
    r_stat = sdspi_pkg::ST_OK;
    r_last = 1'b1;
    unique case (job_q.op)
      sdspi_pkg::JOB_FILL: begin
      end
      sdspi_pkg::JOB_STATUS: begin
        r_kind = sdspi_pkg::KIND_STATUS;
        r_byte = '0;
        r_stat = job_q.status;
      end
      sdspi_pkg::JOB_DELIVER: begin
        if (step_q == '0) begin
          r_kind = sdspi_pkg::KIND_DATA;
          r_byte = job_q.rx;
          r_last = 1'b0;
        end
      end
      sdspi_pkg::JOB_CMD: begin
        r_last = (step_q == sdspi_pkg::STEP_W'(sdspi_pkg::CMD_BYTES - 1));
        case (step_q)
          sdspi_pkg::STEP_W'(0): r_byte = sdspi_pkg::CMD_START | {2'b00, job_q.idx};
          sdspi_pkg::STEP_W'(1): r_byte = job_q.arg[31:24];
          sdspi_pkg::STEP_W'(2): r_byte = job_q.arg[23:16];
          sdspi_pkg::STEP_W'(3): r_byte = job_q.arg[15:8];
          sdspi_pkg::STEP_W'(4): r_byte = job_q.arg[7:0];
          default:               r_byte = crc;
        endcase
      end
    endcase
  end

  always_comb begin
    job_d  = job_q;
    step_d = step_q;
    busy_d = busy_q;
    vld_d  = vld_q;
    kind_d = kind_q;
    byte_d = byte_q;
    stat_d = stat_q;
    last_d = last_q;
    if (can_load) begin
      vld_d = 1'b0;
    end
    if (busy_q) begin
      if (can_load) begin
        vld_d  = 1'b1;
        kind_d = r_kind;
        byte_d = r_byte;
        stat_d = r_stat;
        last_d = r_last;
        step_d = step_q + sdspi_pkg::STEP_W'(1);
        busy_d = !r_last;
      end
    end else if (!empty_i) begin
      job_d  = job_i;
      step_d = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    kind_q <= kind_d;
    byte_q <= byte_d;
    stat_q <= stat_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      vld_q  <= vld_d;
    end
  end

  `SDSPI_ASSERT(a_step_range, !busy_q || step_q < sdspi_pkg::STEP_W'(sdspi_pkg::CMD_BYTES), "sequencer step beyond command frame")
  `SDSPI_ASSERT(a_status_last, !vld_q || kind_q != sdspi_pkg::KIND_STATUS || last_q, "final status not marked last")
  `SDSPI_ASSERT(a_status_kind, !vld_q || kind_q == sdspi_pkg::KIND_STATUS || stat_q == sdspi_pkg::ST_OK, "status set on a byte result")
  `SDSPI_ASSERT_NEXT(a_pop_busy, pop_o, busy_q && step_q == '0, "popped job not taken up")

endmodule
